FILE: rtl/gsdw_pkg.sv
// Package with the shared types, codes and constants of the grid steepest-descent walker.
package gsdw_pkg;

    localparam int GRID_DIM_DEF = 16;
    localparam int CFG_W        = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int HEIGHT_W     = 16;
    localparam int COORD_W      = 4;
    localparam int DIM_W        = 5;
    localparam int BUDGET_W     = 10;
    localparam int NB_W         = 3;

    localparam logic signed [HEIGHT_W-1:0] NO_HEIGHT = 16'sd1000;

    localparam logic [DIM_W-1:0] OFF_NEG  = 5'h1F;
    localparam logic [DIM_W-1:0] OFF_ZERO = 5'h00;
    localparam logic [DIM_W-1:0] OFF_POS  = 5'h01;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_ROWS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_COLS    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_START_ROW    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_START_COL    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MOVE_BUDGET  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT_QUOTA = 3'd5;

    localparam logic [1:0] ACT_WRITE = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_STEP  = 2'd2;

    localparam logic [1:0] OUT_STARTED = 2'd0;
    localparam logic [1:0] OUT_MOVED   = 2'd1;
    localparam logic [1:0] OUT_QUOTA   = 2'd2;
    localparam logic [1:0] OUT_BUDGET  = 2'd3;

    typedef struct packed {
        logic [1:0]                  action;
        logic [COORD_W-1:0]          cell_row;
        logic [COORD_W-1:0]          cell_col;
        logic signed [HEIGHT_W-1:0]  cell_value;
    } t_in_word;

    typedef struct packed {
        logic [COORD_W-1:0]          pos_row;
        logic [COORD_W-1:0]          pos_col;
        logic [1:0]                  outcome;
        logic signed [HEIGHT_W-1:0]  lowest_seen;
    } t_out_word;

    typedef struct packed {
        logic [DIM_W-1:0]            grid_rows;
        logic [DIM_W-1:0]            grid_cols;
        logic [COORD_W-1:0]          start_row;
        logic [COORD_W-1:0]          start_col;
        logic [BUDGET_W-1:0]         move_budget;
        logic signed [HEIGHT_W-1:0]  height_quota;
    } t_cfg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_LAST,
        S_DECIDE,
        S_EMIT
    } t_state;

    // Neighbours are visited in row-major order with the centre left out.
    function automatic logic [DIM_W-1:0] nb_dr(input logic [NB_W-1:0] k);
        logic [DIM_W-1:0] d;
        case (k) inside
            3'd0, 3'd1, 3'd2: d = OFF_NEG;
            3'd3, 3'd4:       d = OFF_ZERO;
            default:          d = OFF_POS;
        endcase
        return d;
    endfunction

    function automatic logic [DIM_W-1:0] nb_dc(input logic [NB_W-1:0] k);
        logic [DIM_W-1:0] d;
        case (k) inside
            3'd0, 3'd3, 3'd5: d = OFF_NEG;
            3'd1, 3'd6:       d = OFF_ZERO;
            default:          d = OFF_POS;
        endcase
        return d;
    endfunction

endpackage

FILE: rtl/grid_steepest_descent_walker.sv
// Top level: configuration registers, height memory, walker sequencer and output register.
// A write word keeps the walker idle; a start word passes the emit state before the next word.
// A step word reads its in-bound neighbours from the height memory's single read port, one per
// cycle, then passes the last, decide and emit states; emit waits until the output slot is free.
// A result sits in the output register while the next word may be accepted.
// Reset clears the walker and sets the registers to their reset values; heights stay undefined.
module grid_steepest_descent_walker #(
    parameter int GRID_DIM = gsdw_pkg::GRID_DIM_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [gsdw_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [gsdw_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  gsdw_pkg::t_in_word               i_word,
    output logic                             o_valid,
    input  logic                             i_ready,
    output gsdw_pkg::t_out_word              o_word
);
    import gsdw_pkg::*;

    localparam int DEPTH = GRID_DIM * GRID_DIM;
    localparam int AW    = $clog2(DEPTH);

    t_cfg                r_cfg;
    logic                r_out_vld;
    t_out_word           r_out_word;
    logic                slot_free;
    logic                push;
    t_out_word           res;
    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [HEIGHT_W-1:0] ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [HEIGHT_W-1:0] ram_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{grid_rows: DIM_W'(16), grid_cols: DIM_W'(16), start_row: '0,
                       start_col: '0, move_budget: '0, height_quota: '0};
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_GRID_ROWS:    r_cfg.grid_rows    <= i_cfg_data[DIM_W-1:0];
                CFG_GRID_COLS:    r_cfg.grid_cols    <= i_cfg_data[DIM_W-1:0];
                CFG_START_ROW:    r_cfg.start_row    <= i_cfg_data[COORD_W-1:0];
                CFG_START_COL:    r_cfg.start_col    <= i_cfg_data[COORD_W-1:0];
                CFG_MOVE_BUDGET:  r_cfg.move_budget  <= i_cfg_data[BUDGET_W-1:0];
                CFG_HEIGHT_QUOTA: r_cfg.height_quota <= signed'(i_cfg_data[HEIGHT_W-1:0]);
                default: begin
                end
            endcase
        end
    end

    gsdw_ram #(
        .WIDTH (HEIGHT_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    gsdw_walk #(
        .GRID_DIM (GRID_DIM),
        .AW       (AW)
    ) u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_in_valid  (i_valid),
        .o_in_ready  (o_ready),
        .i_in_word   (i_word),
        .o_push      (push),
        .o_res       (res),
        .i_slot_free (slot_free),
        .o_ram_we    (ram_we),
        .o_ram_waddr (ram_waddr),
        .o_ram_wdata (ram_wdata),
        .o_ram_re    (ram_re),
        .o_ram_raddr (ram_raddr),
        .i_ram_rdata (ram_rdata)
    );

    assign slot_free = !r_out_vld || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (push) begin
            r_out_vld <= 1'b1;
        end else if (i_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_word <= res;
        end
    end

    assign o_valid = r_out_vld;
    assign o_word  = r_out_word;
endmodule

FILE: rtl/gsdw_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
module gsdw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/gsdw_walk.sv
// Walker sequencer: grid writes, neighbour scan over the height memory and move decision.
module gsdw_walk #(
    parameter int GRID_DIM = gsdw_pkg::GRID_DIM_DEF,
    parameter int AW       = $clog2(GRID_DIM * GRID_DIM)
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  gsdw_pkg::t_cfg              i_cfg,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  gsdw_pkg::t_in_word          i_in_word,
    output logic                        o_push,
    output gsdw_pkg::t_out_word         o_res,
    input  logic                        i_slot_free,
    output logic                        o_ram_we,
    output logic [AW-1:0]               o_ram_waddr,
    output logic [gsdw_pkg::HEIGHT_W-1:0] o_ram_wdata,
    output logic                        o_ram_re,
    output logic [AW-1:0]               o_ram_raddr,
    input  logic [gsdw_pkg::HEIGHT_W-1:0] i_ram_rdata
);
    import gsdw_pkg::*;

    localparam int LIM = (GRID_DIM < 16) ? GRID_DIM : 16;

    t_state r_state, n_state;

    logic [COORD_W-1:0]         r_wrow, n_wrow;
    logic [COORD_W-1:0]         r_wcol, n_wcol;
    logic [BUDGET_W-1:0]        r_moves, n_moves;
    logic                       r_active, n_active;
    logic [NB_W-1:0]            r_k, n_k;
    logic                       r_p_vld, n_p_vld;
    logic [COORD_W-1:0]         r_p_row, n_p_row;
    logic [COORD_W-1:0]         r_p_col, n_p_col;
    logic signed [HEIGHT_W-1:0] r_low, n_low;
    logic [COORD_W-1:0]         r_trow, n_trow;
    logic [COORD_W-1:0]         r_tcol, n_tcol;
    t_out_word                  r_res, n_res;

    logic                       accept;
    logic [DIM_W-1:0]           rows_b;
    logic [DIM_W-1:0]           cols_b;
    logic [DIM_W-1:0]           nr;
    logic [DIM_W-1:0]           nc;
    logic                       inb;
    logic                       wr_inb;
    logic signed [HEIGHT_W-1:0] h;

    assign accept = i_in_valid && o_in_ready;
    assign rows_b = (i_cfg.grid_rows > DIM_W'(LIM)) ? DIM_W'(LIM) : i_cfg.grid_rows;
    assign cols_b = (i_cfg.grid_cols > DIM_W'(LIM)) ? DIM_W'(LIM) : i_cfg.grid_cols;
    assign nr     = {1'b0, r_wrow} + nb_dr(r_k);
    assign nc     = {1'b0, r_wcol} + nb_dc(r_k);
    assign inb    = (nr < rows_b) && (nc < cols_b);
    assign wr_inb = (int'(i_in_word.cell_row) < GRID_DIM)
                    && (int'(i_in_word.cell_col) < GRID_DIM);
    assign h      = signed'(i_ram_rdata);

    assign o_ram_we    = accept && (i_in_word.action == ACT_WRITE) && wr_inb;
    assign o_ram_waddr = AW'(12'(i_in_word.cell_row) * 12'(GRID_DIM)
                             + 12'(i_in_word.cell_col));
    assign o_ram_wdata = i_in_word.cell_value;
    assign o_ram_raddr = AW'(12'(nr[COORD_W-1:0]) * 12'(GRID_DIM)
                             + 12'(nc[COORD_W-1:0]));
    assign o_res       = r_res;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_in_word.action == ACT_START) begin
                    n_state = S_EMIT;
                end else if (accept && i_in_word.action == ACT_STEP && r_active) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (r_k == NB_W'(7)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST:   n_state = S_DECIDE;
            S_DECIDE: n_state = S_EMIT;
            S_EMIT: begin
                if (i_slot_free) begin
                    n_state = S_IDLE;
                end
            end
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        o_ram_re   = (r_state == S_SCAN) && inb;
        o_push     = (r_state == S_EMIT) && i_slot_free;
    end

    always_comb begin
        n_wrow   = r_wrow;
        n_wcol   = r_wcol;
        n_moves  = r_moves;
        n_active = r_active;
        n_k      = r_k;
        n_p_vld  = (r_state == S_SCAN) && inb;
        n_p_row  = nr[COORD_W-1:0];
        n_p_col  = nc[COORD_W-1:0];
        n_low    = r_low;
        n_trow   = r_trow;
        n_tcol   = r_tcol;
        n_res    = r_res;

        if (r_p_vld && (h <= r_low)) begin
            n_low  = h;
            n_trow = r_p_row;
            n_tcol = r_p_col;
        end

        case (r_state)
            S_IDLE: begin
                n_k    = '0;
                n_low  = NO_HEIGHT;
                n_trow = r_wrow;
                n_tcol = r_wcol;
                if (accept && i_in_word.action == ACT_START) begin
                    n_wrow   = i_cfg.start_row;
                    n_wcol   = i_cfg.start_col;
                    n_moves  = i_cfg.move_budget;
                    n_active = 1'b1;
                    n_res    = '{pos_row: i_cfg.start_row, pos_col: i_cfg.start_col,
                                 outcome: OUT_STARTED, lowest_seen: NO_HEIGHT};
                end
            end
            S_SCAN: begin
                n_k = r_k + NB_W'(1);
            end
            S_DECIDE: begin
                if (r_moves == '0) begin
                    n_active = 1'b0;
                    n_res    = '{pos_row: r_wrow, pos_col: r_wcol,
                                 outcome: OUT_BUDGET, lowest_seen: r_low};
                end else if (r_low >= i_cfg.height_quota) begin
                    n_active = 1'b0;
                    n_res    = '{pos_row: r_wrow, pos_col: r_wcol,
                                 outcome: OUT_QUOTA, lowest_seen: r_low};
                end else begin
                    n_wrow  = r_trow;
                    n_wcol  = r_tcol;
                    n_moves = r_moves - BUDGET_W'(1);
                    n_res   = '{pos_row: r_trow, pos_col: r_tcol,
                                outcome: OUT_MOVED, lowest_seen: r_low};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wrow   <= '0;
            r_wcol   <= '0;
            r_moves  <= '0;
            r_active <= 1'b0;
            r_k      <= '0;
            r_p_vld  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wrow   <= n_wrow;
            r_wcol   <= n_wcol;
            r_moves  <= n_moves;
            r_active <= n_active;
            r_k      <= n_k;
            r_p_vld  <= n_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_p_row <= n_p_row;
        r_p_col <= n_p_col;
        r_low   <= n_low;
        r_trow  <= n_trow;
        r_tcol  <= n_tcol;
        r_res   <= n_res;
    end
endmodule
